>>> rtl/core/io_expander_port_with_pin_interrupts_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the I/O expander port unit
// Shared concurrent checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef IO_EXPANDER_PORT_WITH_PIN_INTERRUPTS_UNIT_ASSERT_SVH
`define IO_EXPANDER_PORT_WITH_PIN_INTERRUPTS_UNIT_ASSERT_SVH

// Implication checked on every clock edge out of reset
`define IEPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked on the next clock edge
`define IEPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/iepi_pkg.sv
// ----------------------------------------------------------------------------
// iepi_pkg
// Types, codes and constants shared by the I/O expander port unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iepi_pkg;

  localparam int PIN_COUNT = 8;
  localparam int PORT_BITS = 8;
  localparam int LIVE_PINS = (PIN_COUNT > PORT_BITS) ? PORT_BITS : PIN_COUNT;
  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [7:0] LIVE_MASK = 8'((9'd1 << LIVE_PINS) - 9'd1);
  localparam logic [7:0] LATCH_RESET = FULL_BYTE;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_TOGGLE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_SAMPLE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_RISE = 3'd1,
    MODE_FALL = 3'd2,
    MODE_ANY  = 3'd3,
    MODE_HIGH = 3'd4,
    MODE_LOW  = 3'd5
  } irq_mode_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_MODES     = 2'd1,
    REG_ENABLE    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  direction_mask;
    logic [23:0] interrupt_modes;
    logic [7:0]  interrupt_enable;
  } cfg_t;

  typedef struct packed {
    func_t      func;
    logic [2:0] pin_index;
    logic       level;
    logic [7:0] port_sample;
    logic       sample_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0] port_drive;
    logic       drive_valid;
    logic       pin_level;
    logic [7:0] fire_mask;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/iepi_cfg_regs.sv
// ----------------------------------------------------------------------------
// iepi_cfg_regs
// Configuration register bank: direction, interrupt modes and enables.
// ----------------------------------------------------------------------------
`default_nettype none

module iepi_cfg_regs import iepi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [23:0] wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DIRECTION: cfg_nxt.direction_mask   = wr_data[7:0];
        REG_MODES:     cfg_nxt.interrupt_modes  = wr_data;
        REG_ENABLE:    cfg_nxt.interrupt_enable = wr_data[7:0];
        default:       cfg_nxt = cfg_r;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/iepi_pin_logic.sv
// ----------------------------------------------------------------------------
// iepi_pin_logic
// Per-item datapath: latch update, drive byte, pin read and interrupt firing.
// ----------------------------------------------------------------------------
`default_nettype none

module iepi_pin_logic import iepi_pkg::*; (
  input  wire cmd_t        cmd,
  input  wire cfg_t        cfg,
  input  wire logic [7:0]  latch,
  output logic      [7:0]  latch_nxt,
  output result_t          res
);

  logic       in_range;
  logic [7:0] pin_bit;
  logic [7:0] before_in;
  logic [7:0] after_in;
  logic [7:0] fire;
  logic       changed;

  assign in_range = ({1'b0, cmd.pin_index} < 4'(LIVE_PINS));
  assign pin_bit  = 8'd1 << cmd.pin_index;

  // Interrupt sample: compare input pins before and after the new sample
  assign before_in = latch & cfg.direction_mask;
  assign after_in  = (cmd.sample_ok ? cmd.port_sample : latch) & cfg.direction_mask;
  assign changed   = (before_in != after_in);

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      unique case (irq_mode_t'(cfg.interrupt_modes[3*n +: 3]))
        MODE_RISE: fire[n] = !before_in[n] && after_in[n];
        MODE_FALL: fire[n] = before_in[n] && !after_in[n];
        MODE_ANY:  fire[n] = before_in[n] != after_in[n];
        MODE_HIGH: fire[n] = after_in[n];
        MODE_LOW:  fire[n] = !after_in[n];
        default:   fire[n] = 1'b0;  // none or unknown mode: skip the pin
      endcase
    end
  end

  always_comb begin
    latch_nxt = latch;
    res       = '0;
    if (cmd.func == FUNC_SAMPLE) begin
      if (cmd.sample_ok) begin
        latch_nxt = cmd.port_sample;
      end
      res.fire_mask = changed ? (fire & cfg.interrupt_enable & LIVE_MASK) : 8'd0;
    end else if (in_range) begin
      unique case (cmd.func)
        FUNC_WRITE: begin
          latch_nxt       = cmd.level ? (latch | pin_bit) : (latch & ~pin_bit);
          res.drive_valid = 1'b1;
        end
        FUNC_TOGGLE: begin
          latch_nxt       = latch ^ pin_bit;
          res.drive_valid = 1'b1;
        end
        default: begin
          if (cmd.sample_ok) begin
            latch_nxt = cmd.port_sample;
          end
        end
      endcase
      res.port_drive = res.drive_valid ? (latch_nxt | cfg.direction_mask) : 8'd0;
      res.pin_level  = latch_nxt[cmd.pin_index];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/io_expander_port_with_pin_interrupts_unit.sv
// ----------------------------------------------------------------------------
// io_expander_port_with_pin_interrupts_unit
// Quasi-bidirectional 8-pin port with per-pin edge and level interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transaction (write, toggle, read pin, or an
//           interrupt sample). Exactly one result per command on out_*.
//   out_* : drive byte with its valid flag, addressed pin level, fire mask.
//   cfg_* : register writes (direction, interrupt modes, enables); always
//           ready, only to be issued while no command is in flight.
// An input transaction lands in the input register; the pin logic fills the
// result register from it once that register is free, and out_tvalid rises
// when the result register holds the result. Throughput is one command per
// cycle while the receiver does not stall; the line latch is read and updated
// as each command advances, so consecutive commands see each other's effect
// without bubbles. When the receiver stalls, the result register holds and
// the input register fills; in_tready drops only when both are occupied.
// Reset empties both registers, sets the line latch to all ones (power-on
// port value) and clears all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module io_expander_port_with_pin_interrupts_unit import iepi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // pin_index[2:0], level[3], port_sample[11:4], zero
  input  wire logic [2:0]  in_tuser,   // func[1:0], sample_ok[2]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // port_drive[7:0], pin_level[8], fire_mask[16:9], zero
  output logic             out_tuser,  // drive_valid[0]
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

`include "io_expander_port_with_pin_interrupts_unit_assert.svh"

  cfg_t       cfg;
  cmd_t       cmd_r;
  logic       cmd_valid_r;
  logic       cmd_valid_nxt;
  logic [7:0] latch_r;
  logic [7:0] latch_nxt;
  logic [7:0] latch_calc;
  result_t    res_calc;
  result_t    res_r;
  logic       res_valid_r;
  logic       res_valid_nxt;
  logic       advance;
  logic       in_fire;

  assign cfg_ready = 1'b1;

  iepi_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  iepi_pin_logic u_pin_logic (
    .cmd       (cmd_r),
    .cfg       (cfg),
    .latch     (latch_r),
    .latch_nxt (latch_calc),
    .res       (res_calc)
  );

  // Advance the held command into the result register when that slot frees
  assign advance   = cmd_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !cmd_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cmd_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : cmd_valid_r);
    res_valid_nxt = advance ? 1'b1 : ((out_tready) ? 1'b0 : res_valid_r);
    latch_nxt     = advance ? latch_calc : latch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      latch_r     <= LATCH_RESET;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      res_valid_r <= res_valid_nxt;
      latch_r     <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.func        <= func_t'(in_tuser[1:0]);
      cmd_r.sample_ok   <= in_tuser[2];
      cmd_r.pin_index   <= in_tdata[2:0];
      cmd_r.level       <= in_tdata[3];
      cmd_r.port_sample <= in_tdata[11:4];
    end
    if (advance) begin
      res_r <= res_calc;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tuser  = res_r.drive_valid;
  assign out_tdata  = {7'd0, res_r.fire_mask, res_r.pin_level, res_r.port_drive};

  // Drive byte is zero whenever it is not flagged for sending
  `IEPI_ASSERT_IMP(a_drive_zero, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0,
    "port_drive non-zero without drive_valid")
  // A result never carries both a drive and a fire mask
  `IEPI_ASSERT_IMP(a_drive_xor_fire, out_tvalid && out_tuser, out_tdata[16:9] == 8'd0,
    "fire_mask set on a write or toggle result")
  // The latch moves only when a command is processed
  `IEPI_ASSERT_NEXT(a_latch_hold, !advance, $stable(latch_r),
    "line latch changed without a command advancing")
  // A held command that cannot advance stays in the input register
  `IEPI_ASSERT_NEXT(a_cmd_hold, cmd_valid_r && !advance, cmd_valid_r && $stable(cmd_r),
    "stalled command lost or altered")

endmodule

`default_nettype wire
